>>> src/dpm_pkg.sv
// Shared types, codes and helper functions of the dithered palette mapper.
package dpm_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR_RD,
      ST_ERR_WAIT,
      ST_DIV,
      ST_BAYER,
      ST_SEARCH,
      ST_NXT_RD,
      ST_NXT_WR,
      ST_DONE
   } state_type;

   localparam logic [1:0] MODE_NEAREST = 2'd0;
   localparam logic [1:0] MODE_BAYER   = 2'd1;
   localparam logic [1:0] MODE_FLOYD   = 2'd2;
   localparam logic [1:0] MODE_STRICT  = 2'd3;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_PIXEL = 1'b1;

   localparam logic [1:0] REG_PALETTE_SIZE = 2'd0;
   localparam logic [1:0] REG_DITHER_MODE  = 2'd1;
   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd2;
   localparam logic [1:0] REG_MATRIX_ORDER = 2'd3;

   localparam int ERR_W  = 10;
   localparam int DIST_W = 20;

   typedef struct packed {
      logic clear;
      logic swap;
      logic rd_en;
      logic rd_next;
      logic wr_en;
   } err_cmd_type;

   function automatic logic [7:0] clamp_ch(input logic signed [11:0] v);
      logic [7:0] r;
      if (v < 0) begin
         r = 8'd0;
      end else if (v > 12'sd255) begin
         r = 8'hFF;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

   // signed divide by 16, truncating toward zero
   function automatic logic signed [9:0] trunc16(input logic signed [11:0] v);
      logic [11:0] m;
      logic [9:0] q;
      m = (v < 0) ? 12'(-v) : 12'(v);
      q = 10'(m >> 4);
      return (v < 0) ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic signed [9:0] share(input logic signed [8:0] res,
                                               input logic [3:0] k);
      logic signed [13:0] p;
      p = res * $signed({1'b0, k});
      return trunc16($signed(p[11:0]));
   endfunction

   function automatic logic [7:0] add_err(input logic [7:0] ch,
                                          input logic signed [9:0] e,
                                          input logic signed [9:0] c);
      logic signed [11:0] s;
      s = $signed({4'b0, ch}) + $signed({{2{e[9]}}, e}) + $signed({{2{c[9]}}, c});
      return clamp_ch(s);
   endfunction

   function automatic logic [7:0] add_push(input logic [7:0] ch,
                                           input logic signed [8:0] p);
      logic signed [11:0] s;
      s = $signed({4'b0, ch}) + $signed({{3{p[8]}}, p});
      return clamp_ch(s);
   endfunction

   function automatic logic [5:0] bayer_value(input logic [1:0] order,
                                              input logic [2:0] x,
                                              input logic [2:0] y);
      logic [1:0] d0, d1, d2;
      logic [5:0] v;
      d0 = {x[0] ^ y[0], y[0]};
      d1 = {x[1] ^ y[1], y[1]};
      d2 = {x[2] ^ y[2], y[2]};
      case (order)
         2'd2:    v = {2'b00, d0, d1};
         2'd3:    v = {d0, d1, d2};
         default: v = {4'b0000, d0};
      endcase
      return v;
   endfunction

endpackage

>>> src/dpm_err.sv
// Error row stores: two banks swapped at row end, prefix fill counts stand in for clearing.
module dpm_err #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dpm_pkg::err_cmd_type      cmd,
   input  logic [$clog2(MAX_WIDTH)-1:0] addr,
   input  logic [29:0]               wdata,
   output logic [29:0]               rdata
);
   localparam int CW = $clog2(MAX_WIDTH + 1);

   logic [29:0] mem_a [MAX_WIDTH];
   logic [29:0] mem_b [MAX_WIDTH];
   logic [29:0] a_q_ff, b_q_ff;
   logic        sel_b_ff, ok_ff;
   logic        bank_ff;
   logic [CW-1:0] cur_fill_ff, nxt_fill_ff;
   logic [CW-1:0] addr_ext, addr_inc;

   assign addr_ext = CW'(addr);
   assign addr_inc = addr_ext + CW'(1);

   always_ff @(posedge clock) begin
      if (cmd.wr_en && !bank_ff) begin
         mem_b[addr] <= wdata;
      end
      if (cmd.wr_en && bank_ff) begin
         mem_a[addr] <= wdata;
      end
      if (cmd.rd_en) begin
         a_q_ff   <= mem_a[addr];
         b_q_ff   <= mem_b[addr];
         sel_b_ff <= cmd.rd_next ^ bank_ff;
         ok_ff    <= cmd.rd_next ? (addr_ext < nxt_fill_ff) : (addr_ext < cur_fill_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff     <= 1'b0;
         cur_fill_ff <= '0;
         nxt_fill_ff <= '0;
      end else if (cmd.clear) begin
         cur_fill_ff <= '0;
         nxt_fill_ff <= '0;
      end else if (cmd.swap) begin
         bank_ff     <= ~bank_ff;
         cur_fill_ff <= nxt_fill_ff;
         nxt_fill_ff <= '0;
      end else if (cmd.wr_en && addr_inc > nxt_fill_ff) begin
         nxt_fill_ff <= addr_inc;
      end
   end

   assign rdata = ok_ff ? (sel_b_ff ? b_q_ff : a_q_ff) : 30'd0;

endmodule

>>> src/dpm_dist.sv
// Shared weighted distance unit with running best-entry compare.
module dpm_dist #(
   parameter int IW = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         in_valid,
   input  logic [IW-1:0]                in_idx,
   input  logic [23:0]                  in_colour,
   input  logic [23:0]                  want_colour,
   output logic                         busy,
   output logic [IW-1:0]                best_idx,
   output logic [dpm_pkg::DIST_W-1:0]   best_dist,
   output logic [23:0]                  best_colour
);
   logic signed [8:0]  dr, dg, db;
   logic signed [17:0] pr, pg, pb;
   logic [15:0] sr_ff, sg_ff, sb_ff;
   logic [IW-1:0] s1_idx_ff;
   logic [23:0]   s1_col_ff;
   logic          s1_v_ff;
   logic [dpm_pkg::DIST_W-1:0] dsum;
   logic [IW-1:0]              best_idx_ff;
   logic [dpm_pkg::DIST_W-1:0] best_dist_ff;
   logic [23:0]                best_col_ff;

   assign dr = $signed({1'b0, in_colour[23:16]}) - $signed({1'b0, want_colour[23:16]});
   assign dg = $signed({1'b0, in_colour[15:8]})  - $signed({1'b0, want_colour[15:8]});
   assign db = $signed({1'b0, in_colour[7:0]})   - $signed({1'b0, want_colour[7:0]});
   assign pr = dr * dr;
   assign pg = dg * dg;
   assign pb = db * db;

   always_ff @(posedge clock) begin
      if (reset || start) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      sr_ff     <= pr[15:0];
      sg_ff     <= pg[15:0];
      sb_ff     <= pb[15:0];
      s1_idx_ff <= in_idx;
      s1_col_ff <= in_colour;
   end

   assign dsum = (dpm_pkg::DIST_W'(sr_ff) << 1) + (dpm_pkg::DIST_W'(sg_ff) << 2)
               + (dpm_pkg::DIST_W'(sb_ff) << 1) + dpm_pkg::DIST_W'(sb_ff);

   always_ff @(posedge clock) begin
      if (s1_v_ff && (s1_idx_ff == '0 || dsum < best_dist_ff)) begin
         best_idx_ff  <= s1_idx_ff;
         best_dist_ff <= dsum;
         best_col_ff  <= s1_col_ff;
      end
   end

   assign busy        = s1_v_ff;
   assign best_idx    = best_idx_ff;
   assign best_dist   = best_dist_ff;
   assign best_colour = best_col_ff;

endmodule

>>> src/dithered_palette_mapper.sv
// Dithered palette mapper top level: config port, sequencer, palette store.
// Per pixel: floyd first reads the error rows, bayer first divides and pushes,
// then the palette search and the error row update follow in all modes. One
// pixel at a time, the next word taken in the cycle after the result is registered;
// the palette search (one entry per cycle through the shared distance unit) sets
// the rate. Reset clears control state and sets config registers to defaults;
// palette contents are undefined until loaded.
module dithered_palette_mapper #(
   parameter int PALETTE_DEPTH = 256,
   parameter int MAX_WIDTH     = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_entry_index,
   input  logic [23:0] req_entry_colour,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_palette_index,
   output logic        rsp_mismatch,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int PW = $clog2(PALETTE_DEPTH);
   localparam int NW = $clog2(PALETTE_DEPTH + 1);
   localparam int XW = $clog2(MAX_WIDTH);
   localparam int CW = $clog2(MAX_WIDTH + 1);

   // config registers
   logic [8:0]  palette_size_ff;
   logic [1:0]  dither_mode_ff;
   logic [10:0] image_width_ff;
   logic [1:0]  matrix_order_ff;
   logic        cfg_wr;

   logic [NW-1:0] n_eff;
   logic [CW-1:0] width_eff;
   logic [1:0]    order_eff;
   logic [8:0]    div_m;

   dpm_pkg::state_type state_ff, state_in;

   logic          req_acc, pix_acc, done_go, search_done, op_ok, last_op;
   logic [CW-1:0] col_ff, col_a, col_inc, tgt;
   logic          pre_end, post_end;
   logic [2:0]    phase_ff;
   logic [XW-1:0] x_ff;
   logic [23:0]   pix_ff, want_ff;
   logic [29:0]   carry_ff;
   logic [1:0]    op_ff;
   logic [9:0]    rem_ff, rem_sh;
   logic [8:0]    q_ff;
   logic [3:0]    div_cnt_ff;

   logic [23:0]   pal_mem [PALETTE_DEPTH];
   logic [23:0]   pal_q_ff;
   logic [PW-1:0] pal_idx_ff;
   logic          pal_v_ff;
   logic [NW-1:0] iss_cnt_ff;
   logic          pal_rd;

   logic          rsp_valid_ff, rsp_mismatch_ff;
   logic [7:0]    rsp_index_ff;

   dpm_pkg::err_cmd_type err_cmd;
   logic [XW-1:0] err_addr;
   logic [29:0]   err_wdata, err_rdata;

   logic                       dist_start, dist_busy;
   logic [PW-1:0]              best_idx;
   logic [dpm_pkg::DIST_W-1:0] best_dist;
   logic [23:0]                best_colour;

   logic signed [8:0] res_r, res_g, res_b;
   logic [3:0]        share_k;
   logic              floyd;

   // bayer push
   logic [5:0]         bv;
   logic [2:0]         sh;
   logic signed [7:0]  thr;
   logic signed [16:0] bp;
   logic [16:0]        bmag, bq;
   logic signed [8:0]  push;

   // ---------------- config port ----------------
   assign cfg_wr = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_size_ff <= 9'd256;
         dither_mode_ff  <= dpm_pkg::MODE_NEAREST;
         image_width_ff  <= 11'd1024;
         matrix_order_ff <= 2'd3;
      end else if (cfg_wr) begin
         case (paddr[3:2])
            dpm_pkg::REG_PALETTE_SIZE: palette_size_ff <= pwdata[8:0];
            dpm_pkg::REG_DITHER_MODE:  dither_mode_ff  <= pwdata[1:0];
            dpm_pkg::REG_IMAGE_WIDTH:  image_width_ff  <= pwdata[10:0];
            dpm_pkg::REG_MATRIX_ORDER: matrix_order_ff <= pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         dpm_pkg::REG_PALETTE_SIZE: prdata = {23'd0, palette_size_ff};
         dpm_pkg::REG_DITHER_MODE:  prdata = {30'd0, dither_mode_ff};
         dpm_pkg::REG_IMAGE_WIDTH:  prdata = {21'd0, image_width_ff};
         dpm_pkg::REG_MATRIX_ORDER: prdata = {30'd0, matrix_order_ff};
         default:                   prdata = 32'd0;
      endcase
   end

   always_comb begin
      if (palette_size_ff == 9'd0) begin
         n_eff = NW'(1);
      end else if ({23'd0, palette_size_ff} > 32'(PALETTE_DEPTH)) begin
         n_eff = NW'(PALETTE_DEPTH);
      end else begin
         n_eff = NW'(palette_size_ff);
      end
      if (image_width_ff == 11'd0) begin
         width_eff = CW'(1);
      end else if ({21'd0, image_width_ff} > 32'(MAX_WIDTH)) begin
         width_eff = CW'(MAX_WIDTH);
      end else begin
         width_eff = CW'(image_width_ff);
      end
      order_eff = (matrix_order_ff == 2'd0) ? 2'd1 : matrix_order_ff;
      div_m     = (n_eff < NW'(2)) ? 9'd2 : 9'(n_eff);
   end

   // ---------------- sequencer ----------------
   assign req_stall   = (state_ff != dpm_pkg::ST_IDLE);
   assign req_acc     = req_valid && !req_stall;
   assign pix_acc     = req_acc && (req_func == dpm_pkg::FUNC_PIXEL);
   assign done_go     = (state_ff == dpm_pkg::ST_DONE) && !(rsp_valid_ff && rsp_stall);
   assign search_done = (iss_cnt_ff == n_eff) && !pal_v_ff && !dist_busy;
   assign floyd       = (dither_mode_ff == dpm_pkg::MODE_FLOYD);

   assign col_a    = req_frame_start ? '0 : col_ff;
   assign pre_end  = (col_a >= width_eff);
   assign col_inc  = CW'(x_ff) + CW'(1);
   assign post_end = (col_inc >= width_eff);
   assign tgt      = CW'(x_ff) + CW'(op_ff) - CW'(1);
   assign last_op  = (op_ff == 2'd2);
   assign op_ok    = (op_ff == 2'd1) || (op_ff == 2'd0 && x_ff != '0) ||
                     (op_ff == 2'd2 && !post_end);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dpm_pkg::ST_IDLE: begin
            if (pix_acc) begin
               if (dither_mode_ff == dpm_pkg::MODE_FLOYD) begin
                  state_in = dpm_pkg::ST_ERR_RD;
               end else if (dither_mode_ff == dpm_pkg::MODE_BAYER) begin
                  state_in = dpm_pkg::ST_DIV;
               end else begin
                  state_in = dpm_pkg::ST_SEARCH;
               end
            end
         end
         dpm_pkg::ST_ERR_RD:   state_in = dpm_pkg::ST_ERR_WAIT;
         dpm_pkg::ST_ERR_WAIT: state_in = dpm_pkg::ST_SEARCH;
         dpm_pkg::ST_DIV: begin
            if (div_cnt_ff == 4'd0) begin
               state_in = dpm_pkg::ST_BAYER;
            end
         end
         dpm_pkg::ST_BAYER: state_in = dpm_pkg::ST_SEARCH;
         dpm_pkg::ST_SEARCH: begin
            if (search_done) begin
               state_in = dpm_pkg::ST_NXT_RD;
            end
         end
         dpm_pkg::ST_NXT_RD: begin
            if (op_ok) begin
               state_in = dpm_pkg::ST_NXT_WR;
            end else if (last_op) begin
               state_in = dpm_pkg::ST_DONE;
            end
         end
         dpm_pkg::ST_NXT_WR: begin
            state_in = last_op ? dpm_pkg::ST_DONE : dpm_pkg::ST_NXT_RD;
         end
         dpm_pkg::ST_DONE: begin
            if (done_go) begin
               state_in = dpm_pkg::ST_IDLE;
            end
         end
         default: state_in = dpm_pkg::ST_IDLE;
      endcase
   end

   // residual shares for the next row
   assign res_r = $signed({1'b0, want_ff[23:16]}) - $signed({1'b0, best_colour[23:16]});
   assign res_g = $signed({1'b0, want_ff[15:8]})  - $signed({1'b0, best_colour[15:8]});
   assign res_b = $signed({1'b0, want_ff[7:0]})   - $signed({1'b0, best_colour[7:0]});

   always_comb begin
      case (op_ff)
         2'd0:    share_k = 4'd3;
         2'd1:    share_k = 4'd5;
         default: share_k = 4'd1;
      endcase
   end

   always_comb begin
      err_cmd    = '0;
      err_addr   = x_ff;
      err_wdata  = err_rdata;
      pal_rd     = 1'b0;
      dist_start = 1'b0;
      case (state_ff)
         dpm_pkg::ST_IDLE: begin
            dist_start    = 1'b1;
            err_cmd.clear = pix_acc && req_frame_start;
            err_cmd.swap  = pix_acc && pre_end;
         end
         dpm_pkg::ST_ERR_RD: begin
            err_cmd.rd_en = 1'b1;
         end
         dpm_pkg::ST_SEARCH: begin
            pal_rd = (iss_cnt_ff < n_eff);
         end
         dpm_pkg::ST_NXT_RD: begin
            err_addr        = tgt[XW-1:0];
            err_cmd.rd_en   = op_ok;
            err_cmd.rd_next = 1'b1;
         end
         dpm_pkg::ST_NXT_WR: begin
            err_addr      = tgt[XW-1:0];
            err_cmd.wr_en = 1'b1;
            if (floyd) begin
               err_wdata[29:20] = err_rdata[29:20] + dpm_pkg::share(res_r, share_k);
               err_wdata[19:10] = err_rdata[19:10] + dpm_pkg::share(res_g, share_k);
               err_wdata[9:0]   = err_rdata[9:0]   + dpm_pkg::share(res_b, share_k);
            end
         end
         dpm_pkg::ST_DONE: begin
            err_cmd.swap = done_go && post_end;
         end
         default: ;
      endcase
   end

   // bayer push: thr * spread / half, truncated toward zero
   assign bv   = dpm_pkg::bayer_value(order_eff, x_ff[2:0], phase_ff);
   assign sh   = 3'({order_eff, 1'b0}) - 3'd1;
   assign thr  = $signed({2'b00, bv}) - $signed(8'(7'd1 << sh));
   assign bp   = thr * $signed({1'b0, q_ff});
   assign bmag = (bp < 0) ? 17'(-bp) : 17'(bp);
   assign bq   = bmag >> sh;
   assign push = (bp < 0) ? -$signed(bq[8:0]) : $signed(bq[8:0]);

   assign rem_sh = {rem_ff[8:0], (div_cnt_ff == 4'd8)};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dpm_pkg::ST_IDLE;
         col_ff       <= '0;
         phase_ff     <= 3'd0;
         carry_ff     <= 30'd0;
         pal_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pal_v_ff <= pal_rd;
         if (pix_acc) begin
            if (pre_end) begin
               col_ff   <= '0;
               phase_ff <= (req_frame_start ? 3'd0 : phase_ff) + 3'd1;
            end else begin
               col_ff   <= col_a;
               phase_ff <= req_frame_start ? 3'd0 : phase_ff;
            end
            if (pre_end || req_frame_start) begin
               carry_ff <= 30'd0;
            end
         end
         if (done_go) begin
            if (post_end) begin
               col_ff   <= '0;
               phase_ff <= phase_ff + 3'd1;
               carry_ff <= 30'd0;
            end else begin
               col_ff   <= col_inc;
               carry_ff <= floyd ? {dpm_pkg::share(res_r, 4'd7), dpm_pkg::share(res_g, 4'd7),
                                    dpm_pkg::share(res_b, 4'd7)} : 30'd0;
            end
         end
         if (done_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == dpm_pkg::ST_IDLE) begin
         iss_cnt_ff <= '0;
         op_ff      <= 2'd0;
      end
      if (pix_acc) begin
         x_ff       <= pre_end ? '0 : col_a[XW-1:0];
         pix_ff     <= {req_red, req_green, req_blue};
         want_ff    <= {req_red, req_green, req_blue};
         rem_ff     <= 10'd0;
         q_ff       <= 9'd0;
         div_cnt_ff <= 4'd8;
      end
      if (state_ff == dpm_pkg::ST_ERR_WAIT) begin
         want_ff <= {dpm_pkg::add_err(pix_ff[23:16], err_rdata[29:20], carry_ff[29:20]),
                     dpm_pkg::add_err(pix_ff[15:8],  err_rdata[19:10], carry_ff[19:10]),
                     dpm_pkg::add_err(pix_ff[7:0],   err_rdata[9:0],   carry_ff[9:0])};
      end
      if (state_ff == dpm_pkg::ST_DIV) begin
         div_cnt_ff <= div_cnt_ff - 4'd1;
         if (rem_sh >= {1'b0, div_m}) begin
            rem_ff <= rem_sh - {1'b0, div_m};
            q_ff   <= {q_ff[7:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            q_ff   <= {q_ff[7:0], 1'b0};
         end
      end
      if (state_ff == dpm_pkg::ST_BAYER) begin
         want_ff <= {dpm_pkg::add_push(pix_ff[23:16], push),
                     dpm_pkg::add_push(pix_ff[15:8], push),
                     dpm_pkg::add_push(pix_ff[7:0], push)};
      end
      if (pal_rd) begin
         iss_cnt_ff <= iss_cnt_ff + NW'(1);
         pal_idx_ff <= iss_cnt_ff[PW-1:0];
      end
      if ((state_ff == dpm_pkg::ST_NXT_RD && !op_ok) || state_ff == dpm_pkg::ST_NXT_WR) begin
         op_ff <= op_ff + 2'd1;
      end
      if (done_go) begin
         rsp_index_ff    <= 8'(best_idx);
         rsp_mismatch_ff <= (dither_mode_ff == dpm_pkg::MODE_STRICT) && (best_dist != '0);
      end
   end

   // palette store
   always_ff @(posedge clock) begin
      if (req_acc && req_func == dpm_pkg::FUNC_LOAD &&
          {1'b0, req_entry_index} < 9'(PALETTE_DEPTH)) begin
         pal_mem[req_entry_index[PW-1:0]] <= req_entry_colour;
      end
      if (pal_rd) begin
         pal_q_ff <= pal_mem[iss_cnt_ff[PW-1:0]];
      end
   end

   dpm_dist #(.IW(PW)) u_dist (
      .clock       (clock),
      .reset       (reset),
      .start       (dist_start),
      .in_valid    (pal_v_ff),
      .in_idx      (pal_idx_ff),
      .in_colour   (pal_q_ff),
      .want_colour (want_ff),
      .busy        (dist_busy),
      .best_idx    (best_idx),
      .best_dist   (best_dist),
      .best_colour (best_colour)
   );

   dpm_err #(.MAX_WIDTH(MAX_WIDTH)) u_err (
      .clock (clock),
      .reset (reset),
      .cmd   (err_cmd),
      .addr  (err_addr),
      .wdata (err_wdata),
      .rdata (err_rdata)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_palette_index = rsp_index_ff;
   assign rsp_mismatch      = rsp_mismatch_ff;

endmodule
